// ----- rtl/lrtm_pkg.sv -----
// ----------------------------------------------------------------------------
// lrtm_pkg
// Shared constants, bus types and the gamma table for the tone mapper.
// ----------------------------------------------------------------------------
package lrtm_pkg;

  // Fixed-point format of the radiance channels and gamma table size
  localparam int FRAC_BITS        = 16;
  localparam int GAMMA_TABLE_BITS = 10;

  localparam int CHAN_W = 24;
  localparam int CODE_W = 8;
  localparam int NUM_CH = 3;

  // Channel slots
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Luminance weights, Q0.16, sum is exactly 1.0
  localparam int WGT_W = 16;
  localparam logic [WGT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WGT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WGT_W-1:0] W_BLUE  = 16'd4732;
  localparam logic [NUM_CH-1:0][WGT_W-1:0] LUMA_WGT = {W_BLUE, W_GREEN, W_RED};

  localparam int PROD_W = CHAN_W + WGT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LUM_W  = CHAN_W;

  // Divisor 1 + L, wide enough for both terms
  localparam int DEN_W = ((FRAC_BITS + 1 > LUM_W) ? FRAC_BITS + 1 : LUM_W) + 1;
  localparam logic [DEN_W-1:0] ONE_FX = DEN_W'(1) << FRAC_BITS;

  localparam int QUO_W = FRAC_BITS;

  // Table index from the quotient
  localparam int GAMMA_SIZE = 1 << GAMMA_TABLE_BITS;
  localparam int IDX_SHR    = (FRAC_BITS >= GAMMA_TABLE_BITS) ?
                              FRAC_BITS - GAMMA_TABLE_BITS : 0;
  localparam int IDX_SHL    = (FRAC_BITS >= GAMMA_TABLE_BITS) ?
                              0 : GAMMA_TABLE_BITS - FRAC_BITS;
  localparam int IDX_EXT_W  = QUO_W + IDX_SHL;

  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  // Output queue sized to cover every word in flight
  localparam int PIPE_LAT   = FRAC_BITS + 5;
  localparam int FIFO_DEPTH = 1 << $clog2(PIPE_LAT + 2);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic                     valid;
    chan_t [NUM_CH-1:0]       chan;
    logic [DEN_W-1:0]         den;
  } luma_bus_t;

  typedef struct packed {
    logic                         valid;
    logic [NUM_CH-1:0]            sat;
    logic [NUM_CH-1:0][QUO_W-1:0] quo;
  } quo_bus_t;

  typedef struct packed {
    logic               valid;
    code_t [NUM_CH-1:0] code;
  } code_bus_t;

  // Gamma 1/2.2 as exponent 5/11: entry i is the largest k with
  // k^11 * N^5 <= 255^11 * i^5, N = table size. Built at elaboration.
  localparam int GPOW_NUM = 11;
  localparam int GPOW_DEN = 5;
  localparam int GPOW_W   = CODE_W * GPOW_NUM + GPOW_DEN * GAMMA_TABLE_BITS + 2;

  typedef logic [GPOW_W-1:0] gpow_t;
  typedef logic [GAMMA_SIZE-1:0][CODE_W-1:0] gamma_rom_t;

  function automatic gpow_t gpow(input gpow_t base, input int n);
    gpow_t p;
    int    j;
    p = gpow_t'(1);
    for (j = 0; j < n; j++) begin
      p = p * base;
    end
    return p;
  endfunction

  function automatic gamma_rom_t gamma_rom_build();
    gamma_rom_t rom;
    gpow_t      full;
    gpow_t      rhs;
    gpow_t      lhs;
    code_t      k;
    code_t      t;
    int         i;
    int         b;
    rom  = '0;
    full = gpow(gpow_t'(CODE_MAX), GPOW_NUM);
    for (i = 0; i < GAMMA_SIZE; i++) begin
      rhs = full * gpow(gpow_t'(i), GPOW_DEN);
      k   = '0;
      // binary search, left side is monotonic in k
      for (b = CODE_W - 1; b >= 0; b--) begin
        t   = k | (code_t'(1) << b);
        lhs = gpow(gpow_t'(t), GPOW_NUM) << (GPOW_DEN * GAMMA_TABLE_BITS);
        if (lhs <= rhs) begin
          k = t;
        end
      end
      rom[i] = k;
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = gamma_rom_build();

endpackage

// ----- rtl/lrtm_if.sv -----
// ----------------------------------------------------------------------------
// lrtm_if
// Valid/ready channels for HDR pixels in and display codes out.
// ----------------------------------------------------------------------------
interface lrtm_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrtm_pkg::CHAN_W-1:0] red_in;
  logic [lrtm_pkg::CHAN_W-1:0] green_in;
  logic [lrtm_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface lrtm_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [lrtm_pkg::CODE_W-1:0] red_out;
  logic [lrtm_pkg::CODE_W-1:0] green_out;
  logic [lrtm_pkg::CODE_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ----- rtl/luminance_reinhard_tone_mapper.sv -----
// ----------------------------------------------------------------------------
// luminance_reinhard_tone_mapper
// Reinhard tone mapping on luminance with gamma 1/2.2, Q8.16 in, 8-bit out.
// ----------------------------------------------------------------------------
// Path: an accepted word runs through the luma stages, the one-bit-per-stage
//   divider, the gamma read and the output queue, in that order; words are Q8.16.
// Throughput: one pixel per clock; in_pix.ready drops only when the
//   FIFO_DEPTH-word output queue (32 at defaults) plus words in flight is full.
// Reset: synchronous, active low; clears valid bits, pointers and counters.
//   No clearing pass, the block takes words right after reset.
// ----------------------------------------------------------------------------
module luminance_reinhard_tone_mapper (
  input  logic            clk,
  input  logic            rst_n,
  lrtm_pix_in_if.sink     in_pix,
  lrtm_pix_out_if.source  out_pix
);

  // Datapath:
  //   luma  : 2 stages, weighted products then L and the divisor 1 + L
  //   div   : 1 + FRAC_BITS stages, saturation check then a quotient bit each
  //   gamma : 1 stage, table read
  //   fifo  : output queue, parts the never-stalling pipe from out_pix.ready
  // With L = 0 the divisor is exactly 1.0, so the divider returns c itself
  // and the pass-through case needs no separate path.

  lrtm_pkg::chan_t [lrtm_pkg::NUM_CH-1:0] in_chan;
  lrtm_pkg::luma_bus_t                    luma;
  lrtm_pkg::quo_bus_t                     quo;
  lrtm_pkg::code_bus_t                    code;
  logic                                   take;
  logic                                   credit_ok;

  assign in_chan[lrtm_pkg::CH_RED]   = in_pix.red_in;
  assign in_chan[lrtm_pkg::CH_GREEN] = in_pix.green_in;
  assign in_chan[lrtm_pkg::CH_BLUE]  = in_pix.blue_in;

  // ready comes from the credit count only, not from the output side
  assign in_pix.ready = credit_ok;
  assign take         = in_pix.valid & credit_ok;

  lrtm_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (take),
    .in_chan  (in_chan),
    .luma     (luma)
  );

  lrtm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .luma  (luma),
    .quo   (quo)
  );

  lrtm_gamma u_gamma (
    .clk   (clk),
    .rst_n (rst_n),
    .quo   (quo),
    .code  (code)
  );

  lrtm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .credit_ok (credit_ok),
    .wr        (code),
    .out_pix   (out_pix)
  );

endmodule

// ----- rtl/lrtm_luma.sv -----
// ----------------------------------------------------------------------------
// lrtm_luma
// Two stages: weighted products, then sum to luminance and form 1 + L.
// ----------------------------------------------------------------------------
module lrtm_luma (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  lrtm_pkg::chan_t [lrtm_pkg::NUM_CH-1:0]     in_chan,
  output lrtm_pkg::luma_bus_t                        luma
);

  logic                                                  va_r;
  logic                                                  vb_r;
  lrtm_pkg::chan_t [lrtm_pkg::NUM_CH-1:0]                ca_r;
  lrtm_pkg::chan_t [lrtm_pkg::NUM_CH-1:0]                cb_r;
  logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::PROD_W-1:0]    prod_r;
  logic [lrtm_pkg::DEN_W-1:0]                            den_r;
  logic [lrtm_pkg::SUM_W-1:0]                            sum;
  logic [lrtm_pkg::LUM_W-1:0]                            lum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_comb begin
    sum = lrtm_pkg::SUM_W'(prod_r[lrtm_pkg::CH_RED])
        + lrtm_pkg::SUM_W'(prod_r[lrtm_pkg::CH_GREEN])
        + lrtm_pkg::SUM_W'(prod_r[lrtm_pkg::CH_BLUE]);
    lum = sum[lrtm_pkg::WGT_W +: lrtm_pkg::LUM_W];
  end

  always_ff @(posedge clk) begin
    ca_r <= in_chan;
    for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
      prod_r[ch] <= lrtm_pkg::PROD_W'(lrtm_pkg::LUMA_WGT[ch])
                  * lrtm_pkg::PROD_W'(in_chan[ch]);
    end
    cb_r  <= ca_r;
    den_r <= lrtm_pkg::ONE_FX + lrtm_pkg::DEN_W'(lum);
  end

  assign luma.valid = vb_r;
  assign luma.chan  = cb_r;
  assign luma.den   = den_r;

endmodule

// ----- rtl/lrtm_div.sv -----
// ----------------------------------------------------------------------------
// lrtm_div
// Pipelined restoring divider, three lanes: q = (c << FRAC_BITS) / (1 + L).
// One quotient bit per stage; c >= 1 + L is flagged as saturated up front.
// ----------------------------------------------------------------------------
module lrtm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lrtm_pkg::luma_bus_t luma,
  output lrtm_pkg::quo_bus_t  quo
);

  logic [lrtm_pkg::FRAC_BITS:0]                          vld_r;
  logic [lrtm_pkg::DEN_W-1:0]                            den_r [lrtm_pkg::FRAC_BITS+1];
  logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::DEN_W-1:0]     rem_r [lrtm_pkg::FRAC_BITS+1];
  logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::QUO_W-1:0]     q_r   [lrtm_pkg::FRAC_BITS+1];
  logic [lrtm_pkg::NUM_CH-1:0]                           sat_r [lrtm_pkg::FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[lrtm_pkg::FRAC_BITS-1:0], luma.valid};
    end
  end

  // entry stage: saturation check, remainder starts at c (at zero if saturated)
  always_ff @(posedge clk) begin
    den_r[0] <= luma.den;
    for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
      sat_r[0][ch] <= lrtm_pkg::DEN_W'(luma.chan[ch]) >= luma.den;
      rem_r[0][ch] <= (lrtm_pkg::DEN_W'(luma.chan[ch]) >= luma.den) ?
                      '0 : lrtm_pkg::DEN_W'(luma.chan[ch]);
      q_r[0][ch]   <= '0;
    end
  end

  for (genvar s = 1; s <= lrtm_pkg::FRAC_BITS; s++) begin : g_step
    logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::DEN_W:0]   shl;
    logic [lrtm_pkg::NUM_CH-1:0]                      ge;
    logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::DEN_W-1:0] rem_nxt;

    always_comb begin
      for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
        shl[ch]     = {rem_r[s-1][ch], 1'b0};
        ge[ch]      = shl[ch] >= {1'b0, den_r[s-1]};
        rem_nxt[ch] = ge[ch] ? lrtm_pkg::DEN_W'(shl[ch] - {1'b0, den_r[s-1]})
                             : lrtm_pkg::DEN_W'(shl[ch]);
      end
    end

    always_ff @(posedge clk) begin
      den_r[s] <= den_r[s-1];
      sat_r[s] <= sat_r[s-1];
      rem_r[s] <= rem_nxt;
      for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
        q_r[s][ch] <= {q_r[s-1][ch][lrtm_pkg::QUO_W-2:0], ge[ch]};
      end
    end
  end

  assign quo.valid = vld_r[lrtm_pkg::FRAC_BITS];
  assign quo.sat   = sat_r[lrtm_pkg::FRAC_BITS];
  assign quo.quo   = q_r[lrtm_pkg::FRAC_BITS];

  // remainder must stay below the divisor in every lane
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[lrtm_pkg::FRAC_BITS] |->
      (rem_r[lrtm_pkg::FRAC_BITS][lrtm_pkg::CH_RED]   < den_r[lrtm_pkg::FRAC_BITS]) &&
      (rem_r[lrtm_pkg::FRAC_BITS][lrtm_pkg::CH_GREEN] < den_r[lrtm_pkg::FRAC_BITS]) &&
      (rem_r[lrtm_pkg::FRAC_BITS][lrtm_pkg::CH_BLUE]  < den_r[lrtm_pkg::FRAC_BITS]))
    else $error("divider remainder out of range");

endmodule

// ----- rtl/lrtm_gamma.sv -----
// ----------------------------------------------------------------------------
// lrtm_gamma
// Gamma table lookup with registered read; saturated lanes give full code.
// ----------------------------------------------------------------------------
module lrtm_gamma (
  input  logic                clk,
  input  logic                rst_n,
  input  lrtm_pkg::quo_bus_t  quo,
  output lrtm_pkg::code_bus_t code
);

  logic [lrtm_pkg::NUM_CH-1:0][lrtm_pkg::GAMMA_TABLE_BITS-1:0] idx;
  logic                                                         vld_r;
  logic [lrtm_pkg::NUM_CH-1:0]                                  sat_r;
  lrtm_pkg::code_t [lrtm_pkg::NUM_CH-1:0]                       rom_r;

  always_comb begin
    for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
      idx[ch] = lrtm_pkg::GAMMA_TABLE_BITS'(
                  (lrtm_pkg::IDX_EXT_W'(quo.quo[ch]) << lrtm_pkg::IDX_SHL)
                  >> lrtm_pkg::IDX_SHR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= quo.valid;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= quo.sat;
    for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
      rom_r[ch] <= lrtm_pkg::GAMMA_ROM[idx[ch]];
    end
  end

  always_comb begin
    code.valid = vld_r;
    for (int ch = 0; ch < lrtm_pkg::NUM_CH; ch++) begin
      code.code[ch] = sat_r[ch] ? lrtm_pkg::CODE_MAX : rom_r[ch];
    end
  end

endmodule

// ----- rtl/lrtm_fifo.sv -----
// ----------------------------------------------------------------------------
// lrtm_fifo
// Output queue with credit count; a credit covers each word from acceptance
// until it leaves, so the non-stalling pipeline can never overrun the queue.
// ----------------------------------------------------------------------------
module lrtm_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  output logic                   credit_ok,
  input  lrtm_pkg::code_bus_t    wr,
  lrtm_pix_out_if.source         out_pix
);

  lrtm_pkg::code_t [lrtm_pkg::NUM_CH-1:0] mem [lrtm_pkg::FIFO_DEPTH];
  lrtm_pkg::code_t [lrtm_pkg::NUM_CH-1:0] rd_word;
  logic [lrtm_pkg::PTR_W-1:0]             wr_ptr_r;
  logic [lrtm_pkg::PTR_W-1:0]             rd_ptr_r;
  logic [lrtm_pkg::CNT_W-1:0]             fill_r;
  logic [lrtm_pkg::CNT_W-1:0]             credit_r;
  logic                                   pop;

  assign pop       = out_pix.valid & out_pix.ready;
  assign credit_ok = credit_r < lrtm_pkg::CNT_W'(lrtm_pkg::FIFO_DEPTH);

  assign rd_word           = mem[rd_ptr_r];
  assign out_pix.valid     = fill_r != '0;
  assign out_pix.red_out   = rd_word[lrtm_pkg::CH_RED];
  assign out_pix.green_out = rd_word[lrtm_pkg::CH_GREEN];
  assign out_pix.blue_out  = rd_word[lrtm_pkg::CH_BLUE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      if (wr.valid) begin
        wr_ptr_r <= wr_ptr_r + lrtm_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + lrtm_pkg::PTR_W'(1);
      end
      fill_r   <= fill_r + lrtm_pkg::CNT_W'(wr.valid) - lrtm_pkg::CNT_W'(pop);
      credit_r <= credit_r + lrtm_pkg::CNT_W'(take) - lrtm_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr_ptr_r] <= wr.code;
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= lrtm_pkg::CNT_W'(lrtm_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_fill_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= credit_r)
    else $error("queue holds more words than were accepted");

  a_wr_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    wr.valid |-> fill_r < credit_r)
    else $error("pipeline word arrived without a credit");

endmodule
